// File: rtl/tgcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture command decoder package
// Shared types, event and command codes, and register reset values.
// ----------------------------------------------------------------------------
package tgcd_pkg;

	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned FIFO_DEPTH  = 4;
	localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [15:0] COMBO_WINDOW_RESET = 16'd2000;

	localparam logic [CFG_IDX_W-1:0] CFG_COMBO_WINDOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHOTO_ENABLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_PRESENT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTION_PRESENT = 2'd3;

	localparam logic [2:0] FUNC_PRESS      = 3'd0;
	localparam logic [2:0] FUNC_RELEASE    = 3'd1;
	localparam logic [2:0] FUNC_LONG       = 3'd2;
	localparam logic [2:0] FUNC_TICK       = 3'd3;
	localparam logic [2:0] FUNC_PHOTO_DONE = 3'd4;

	localparam logic [1:0] BTN_ONE   = 2'd1;
	localparam logic [1:0] BTN_TWO   = 2'd2;
	localparam logic [1:0] BTN_THREE = 2'd3;

	typedef enum logic [3:0] {
		CMD_NONE      = 4'd0,
		CMD_INIT      = 4'd1,
		CMD_STEP_FWD  = 4'd2,
		CMD_STEP_BACK = 4'd3,
		CMD_STAND     = 4'd4,
		CMD_LIE       = 4'd5,
		CMD_RUN_FWD   = 4'd6,
		CMD_RUN_BACK  = 4'd7,
		CMD_STOP      = 4'd8,
		CMD_BIG_FWD   = 4'd9,
		CMD_BIG_BACK  = 4'd10,
		CMD_PHOTO     = 4'd11
	} cmd_e;

	typedef struct packed {
		logic [2:0] func;
		logic [1:0] button;
		logic       locomotion_active;
	} evt_t;

	typedef struct packed {
		cmd_e command;
		logic last;
	} res_t;

	typedef struct packed {
		logic [15:0] combo_window_ms;
		logic        photo_enable;
		logic        camera_present;
		logic        motion_present;
	} cfg_t;

	// index 0 is button two (forward), index 1 is button three (back)
	typedef struct packed {
		logic [15:0] combo_remaining;
		logic        b1_long_seen;
		logic [1:0]  held;
		logic [1:0]  long_seen;
		logic [1:0]  combo_touch;
		logic [1:0]  gesture_long;
		logic        dual_stop_pending;
		logic        photo_busy;
	} state_t;

	typedef struct packed {
		logic [1:0] count;
		cmd_e       cmd0;
		cmd_e       cmd1;
	} push_t;

endpackage

// File: rtl/tgcd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture command decoder engine
// Holds gesture state and decodes one registered event per cycle, while advance
// is high, into up to two commands.
// ----------------------------------------------------------------------------
module tgcd_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  tgcd_pkg::evt_t  evt,
	input  tgcd_pkg::cfg_t  cfg,
	output tgcd_pkg::push_t push
);
	import tgcd_pkg::*;

	state_t     st_q;
	state_t     st_d;
	logic       k;
	logic       win;
	logic       touch;
	logic       short_press;
	logic       photo_req;
	logic [1:0] cnt;
	cmd_e       c0;
	cmd_e       c1;

	always_comb begin
		st_d        = st_q;
		cnt         = 2'd0;
		c0          = CMD_NONE;
		c1          = CMD_NONE;
		photo_req   = 1'b0;
		touch       = 1'b0;
		short_press = 1'b0;
		k           = evt.button[0];
		win         = st_q.combo_remaining != 16'd0;
		unique case (evt.func)
			FUNC_PRESS: begin
				if (evt.button == BTN_ONE) begin
					st_d.b1_long_seen = 1'b0;
				end else if (evt.button[1] && cfg.motion_present) begin
					st_d.held[k]         = 1'b1;
					st_d.gesture_long[k] = 1'b0;
					st_d.long_seen[k]    = 1'b0;
					if (win) begin
						st_d.combo_touch[k] = 1'b1;
					end else begin
						if (st_q.held[~k]) st_d.dual_stop_pending = 1'b1;
						if (!evt.locomotion_active) begin
							c0  = k ? CMD_STEP_BACK : CMD_STEP_FWD;
							cnt = 2'd1;
							if (!k) photo_req = 1'b1;
						end
					end
				end
			end
			FUNC_RELEASE: begin
				if (evt.button == BTN_ONE) begin
					st_d.b1_long_seen = 1'b0;
					if (!st_q.b1_long_seen) photo_req = 1'b1;
				end else if (evt.button[1] && cfg.motion_present) begin
					st_d.held[k]        = 1'b0;
					touch               = st_q.combo_touch[k];
					short_press         = !st_q.long_seen[k];
					st_d.combo_touch[k] = 1'b0;
					st_d.long_seen[k]   = 1'b0;
					if (win && touch && short_press) begin
						c0  = k ? CMD_BIG_BACK : CMD_BIG_FWD;
						cnt = 2'd1;
						st_d.combo_remaining = 16'd0;
					end
					if (st_d.held == 2'b00) begin
						if (st_q.dual_stop_pending && st_q.gesture_long == 2'b00
								&& evt.locomotion_active) begin
							if (cnt == 2'd0) c0 = CMD_STOP;
							else c1 = CMD_STOP;
							cnt = cnt + 2'd1;
						end
						st_d.dual_stop_pending = 1'b0;
						st_d.gesture_long      = 2'b00;
					end
				end
			end
			FUNC_LONG: begin
				if (evt.button == BTN_ONE) begin
					st_d.b1_long_seen = 1'b1;
					if (cfg.motion_present) begin
						c0  = CMD_INIT;
						cnt = 2'd1;
						st_d.combo_remaining = cfg.combo_window_ms;
					end
				end else if (evt.button[1]) begin
					st_d.long_seen[k]      = 1'b1;
					st_d.gesture_long[k]   = 1'b1;
					st_d.dual_stop_pending = 1'b0;
					if (cfg.motion_present) begin
						cnt = 2'd1;
						if (win) begin
							c0 = k ? CMD_LIE : CMD_STAND;
							st_d.combo_remaining = 16'd0;
						end else begin
							c0 = k ? CMD_RUN_BACK : CMD_RUN_FWD;
						end
					end
				end
			end
			FUNC_TICK: begin
				if (win) st_d.combo_remaining = st_q.combo_remaining - 16'd1;
			end
			FUNC_PHOTO_DONE: begin
				st_d.photo_busy = 1'b0;
			end
			default: begin
			end
		endcase
		if (photo_req && cfg.photo_enable && cfg.camera_present && !st_q.photo_busy) begin
			st_d.photo_busy = 1'b1;
			if (cnt == 2'd0) c0 = CMD_PHOTO;
			else c1 = CMD_PHOTO;
			cnt = cnt + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	assign push.count = advance ? cnt : 2'd0;
	assign push.cmd0  = c0;
	assign push.cmd1  = c1;

endmodule

// File: rtl/tgcd_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture command decoder result queue
// Takes zero to two results per cycle and hands out one per transaction.
// ----------------------------------------------------------------------------
module tgcd_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  tgcd_pkg::push_t push,
	output logic            room,
	output logic            cmd_valid,
	input  logic            cmd_stall,
	output tgcd_pkg::res_t  cmd
);
	import tgcd_pkg::*;

	res_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;
	res_t                  ent0;
	res_t                  ent1;

	assign pop       = cmd_valid && !cmd_stall;
	assign cmd_valid = count_q != '0;
	assign cmd       = mem_q[rd_ptr_q];
	assign room      = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

	assign ent0.command = push.cmd0;
	assign ent0.last    = push.count == 2'd1;
	assign ent1.command = push.cmd1;
	assign ent1.last    = 1'b1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_ptr_q] <= ent0;
		if (push.count == 2'd2) mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= ent1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.count);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			count_q <= count_q + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
		end
	end

endmodule

// File: rtl/touch_gesture_command_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture command decoder core
// Path: an accepted event is held in the input register, decoded, and its
// commands are written into the output queue; the second follows the first.
// Throughput: one event per cycle while the queue has room; the output queue
// drains one command per cycle unless stalled, one transaction per command.
// Reset: gesture state, queue, config and valid flag return to defaults at once.
// ----------------------------------------------------------------------------
module touch_gesture_command_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                evt_valid,
	output logic                                evt_stall,
	input  tgcd_pkg::evt_t                      evt,
	output logic                                cmd_valid,
	input  logic                                cmd_stall,
	output tgcd_pkg::res_t                      cmd,
	input  logic                                cfg_we,
	input  logic [tgcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tgcd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import tgcd_pkg::*;

	cfg_t  cfg_q;
	evt_t  evt_s1;
	logic  evt_valid_s1;
	logic  room;
	logic  advance;
	push_t push;

	assign advance   = evt_valid_s1 && room;
	assign evt_stall = evt_valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.combo_window_ms <= COMBO_WINDOW_RESET;
			cfg_q.photo_enable    <= 1'b0;
			cfg_q.camera_present  <= 1'b0;
			cfg_q.motion_present  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COMBO_WINDOW:   cfg_q.combo_window_ms <= cfg_wdata;
				CFG_PHOTO_ENABLE:   cfg_q.photo_enable    <= cfg_wdata[0];
				CFG_CAMERA_PRESENT: cfg_q.camera_present  <= cfg_wdata[0];
				CFG_MOTION_PRESENT: cfg_q.motion_present  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			evt_valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) evt_s1 <= evt;
	end

	tgcd_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.evt     (evt_s1),
		.cfg     (cfg_q),
		.push    (push)
	);

	tgcd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd)
	);

endmodule

// File: tb/sv/touch_gesture_command_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture command decoder core testbench
// Drives button, tick and photo-done events and register writes, and predicts
// the commands of each accepted event with a local gesture model. Every
// command transaction is checked in order against the predicted commands.
// Runs directed gesture tests, then random gesture mixes under several
// register settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module touch_gesture_command_decoder_core_tb;
	import tgcd_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 300000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt = '0;
	logic cmd_valid;
	logic cmd_stall = 1'b0;
	res_t cmd;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	touch_gesture_command_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_HALF) clk = ~clk;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int sent_events = 0;
	int checked_cmds = 0;
	int mismatches = 0;
	int cycles = 0;
	int config_writes = 0;

	// gesture model: registers and state
	logic [15:0] win_ms;
	bit photo_en, camera_on, motion_on;
	logic [15:0] combo_left;
	bit b1_long, held2, held3, long2, long3, touch2, touch3;
	bit glong2, glong3, dual_pending, photo_busy;
	cmd_e event_cmds[$];
	res_t expected_cmds[$];
	res_t want_cmd;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic reset_model();
		win_ms = COMBO_WINDOW_RESET;
		photo_en = 1'b0;
		camera_on = 1'b0;
		motion_on = 1'b1;
		combo_left = '0;
		{b1_long, held2, held3, long2, long3, touch2, touch3} = '0;
		{glong2, glong3, dual_pending, photo_busy} = '0;
	endtask

	task automatic add_cmd(input cmd_e c);
		if (event_cmds.size() < 2)
			event_cmds.push_back(c);
	endtask

	task automatic ask_photo();
		if (photo_en && camera_on && !photo_busy) begin
			photo_busy = 1'b1;
			add_cmd(CMD_PHOTO);
		end
	endtask

	task automatic check_dual_stop(input bit loco);
		if (held2 || held3)
			return;
		if (dual_pending && !glong2 && !glong3 && loco)
			add_cmd(CMD_STOP);
		dual_pending = 1'b0;
		glong2 = 1'b0;
		glong3 = 1'b0;
	endtask

	task automatic press_motion(input bit fwd, input bit loco);
		bit other;
		other = fwd ? held3 : held2;
		if (!motion_on)
			return;
		if (fwd) begin
			held2 = 1'b1;
			glong2 = 1'b0;
		end else begin
			held3 = 1'b1;
			glong3 = 1'b0;
		end
		if (combo_left != 0) begin
			if (fwd) begin
				touch2 = 1'b1;
				long2 = 1'b0;
			end else begin
				touch3 = 1'b1;
				long3 = 1'b0;
			end
			return;
		end
		if (fwd)
			long2 = 1'b0;
		else
			long3 = 1'b0;
		if (other)
			dual_pending = 1'b1;
		if (loco)
			return;
		if (fwd) begin
			add_cmd(CMD_STEP_FWD);
			ask_photo();
		end else begin
			add_cmd(CMD_STEP_BACK);
		end
	endtask

	task automatic release_motion(input bit fwd, input bit loco);
		bit touched, short_press;
		if (!motion_on)
			return;
		if (fwd) begin
			held2 = 1'b0;
			touched = touch2;
			short_press = !long2;
			touch2 = 1'b0;
			long2 = 1'b0;
		end else begin
			held3 = 1'b0;
			touched = touch3;
			short_press = !long3;
			touch3 = 1'b0;
			long3 = 1'b0;
		end
		if (combo_left != 0 && touched && short_press) begin
			add_cmd(fwd ? CMD_BIG_FWD : CMD_BIG_BACK);
			combo_left = '0;
		end
		check_dual_stop(loco);
	endtask

	task automatic long_motion(input bit fwd);
		if (fwd) begin
			long2 = 1'b1;
			glong2 = 1'b1;
		end else begin
			long3 = 1'b1;
			glong3 = 1'b1;
		end
		dual_pending = 1'b0;
		if (!motion_on)
			return;
		if (combo_left != 0) begin
			add_cmd(fwd ? CMD_STAND : CMD_LIE);
			combo_left = '0;
			return;
		end
		add_cmd(fwd ? CMD_RUN_FWD : CMD_RUN_BACK);
	endtask

	task automatic predict_commands(input evt_t e);
		res_t r;
		event_cmds.delete();
		case (e.func)
			FUNC_PRESS: begin
				if (e.button == BTN_ONE)
					b1_long = 1'b0;
				else if (e.button == BTN_TWO)
					press_motion(1'b1, e.locomotion_active);
				else if (e.button == BTN_THREE)
					press_motion(1'b0, e.locomotion_active);
			end
			FUNC_RELEASE: begin
				if (e.button == BTN_ONE) begin
					if (!b1_long)
						ask_photo();
					b1_long = 1'b0;
				end else if (e.button == BTN_TWO) begin
					release_motion(1'b1, e.locomotion_active);
				end else if (e.button == BTN_THREE) begin
					release_motion(1'b0, e.locomotion_active);
				end
			end
			FUNC_LONG: begin
				if (e.button == BTN_ONE) begin
					b1_long = 1'b1;
					if (motion_on) begin
						add_cmd(CMD_INIT);
						combo_left = win_ms;
					end
				end else if (e.button == BTN_TWO) begin
					long_motion(1'b1);
				end else if (e.button == BTN_THREE) begin
					long_motion(1'b0);
				end
			end
			FUNC_TICK: begin
				if (combo_left != 0)
					combo_left = combo_left - 16'd1;
			end
			FUNC_PHOTO_DONE: begin
				photo_busy = 1'b0;
			end
			default: begin
			end
		endcase
		for (int i = 0; i < event_cmds.size(); i++) begin
			r.command = event_cmds[i];
			r.last = (i == event_cmds.size() - 1);
			expected_cmds.push_back(r);
		end
	endtask

	always @(negedge clk)
		cmd_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) begin
			if (expected_cmds.size() == 0) begin
				report_mismatch($sformatf("unexpected command %0d", cmd.command));
			end else begin
				want_cmd = expected_cmds.pop_front();
				if (cmd.command !== want_cmd.command)
					report_mismatch($sformatf("command %0d, expected %0d",
						cmd.command, want_cmd.command));
				if (cmd.last !== want_cmd.last)
					report_mismatch($sformatf("last %0b, expected %0b for command %0d",
						cmd.last, want_cmd.last, want_cmd.command));
				checked_cmds++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d commands outstanding",
				cycles, expected_cmds.size());
			$display("touch_gesture_command_decoder_core verification failed");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_event(input logic [2:0] func, input logic [1:0] button,
			input bit loco);
		evt_t e;
		int gap;
		e.func = func;
		e.button = button;
		e.locomotion_active = loco;
		gap = 0;
		while (gap < 16 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_valid <= 1'b1;
		evt <= e;
		do
			@(posedge clk);
		while (evt_stall !== 1'b0);
		predict_commands(e);
		sent_events++;
		@(negedge clk);
	endtask

	task automatic settle();
		evt_valid <= 1'b0;
		@(negedge clk);
		while (expected_cmds.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_COMBO_WINDOW: win_ms = data;
			CFG_PHOTO_ENABLE: photo_en = data[0];
			CFG_CAMERA_PRESENT: camera_on = data[0];
			CFG_MOTION_PRESENT: motion_on = data[0];
			default: begin
			end
		endcase
		config_writes++;
	endtask

	task automatic configure(input logic [15:0] window, input bit pe, input bit cam,
			input bit mot);
		settle();
		write_reg(CFG_COMBO_WINDOW, window);
		write_reg(CFG_PHOTO_ENABLE, {15'($urandom_range(0, 32767)), pe});
		write_reg(CFG_CAMERA_PRESENT, {15'($urandom_range(0, 32767)), cam});
		write_reg(CFG_MOTION_PRESENT, {15'($urandom_range(0, 32767)), mot});
	endtask

	task automatic test_combo_window();
		send_event(FUNC_LONG, BTN_ONE, 1'b0);
		send_event(FUNC_PRESS, BTN_TWO, 1'b0);
		send_event(FUNC_RELEASE, BTN_TWO, 1'b0);
		send_event(FUNC_PRESS, BTN_THREE, 1'b0);
		send_event(FUNC_LONG, BTN_THREE, 1'b0);
		send_event(FUNC_RELEASE, BTN_THREE, 1'b0);
		configure(16'hFFFF, 1'b0, 1'b0, 1'b1);
		send_event(FUNC_LONG, BTN_ONE, 1'b1);
		send_event(FUNC_LONG, BTN_TWO, 1'b1);
		send_event(FUNC_LONG, BTN_ONE, 1'b0);
		send_event(FUNC_LONG, BTN_THREE, 1'b1);
	endtask

	task automatic test_steps_and_photo();
		configure(16'd1, 1'b1, 1'b1, 1'b1);
		send_event(FUNC_LONG, BTN_ONE, 1'b0);
		send_event(FUNC_TICK, 2'd0, 1'b1);
		send_event(FUNC_PRESS, BTN_TWO, 1'b0);
		send_event(FUNC_RELEASE, BTN_TWO, 1'b0);
		send_event(FUNC_RELEASE, BTN_ONE, 1'b0);
		send_event(FUNC_PHOTO_DONE, 2'd3, 1'b1);
		send_event(FUNC_RELEASE, BTN_ONE, 1'b0);
		send_event(FUNC_PHOTO_DONE, 2'd0, 1'b0);
	endtask

	task automatic test_dual_stop();
		send_event(FUNC_PRESS, BTN_TWO, 1'b1);
		send_event(FUNC_PRESS, BTN_THREE, 1'b1);
		send_event(FUNC_RELEASE, BTN_TWO, 1'b1);
		send_event(FUNC_RELEASE, BTN_THREE, 1'b1);
	endtask

	task automatic test_ignored_events();
		send_event(3'd7, BTN_THREE, 1'b1);
		send_event(3'd5, BTN_TWO, 1'b0);
		send_event(FUNC_PRESS, 2'd0, 1'b0);
		send_event(FUNC_LONG, 2'd0, 1'b1);
	endtask

	task automatic test_no_motion_controller();
		configure(16'd0, 1'b1, 1'b1, 1'b0);
		send_event(FUNC_LONG, BTN_ONE, 1'b0);
		send_event(FUNC_RELEASE, BTN_ONE, 1'b0);
		send_event(FUNC_PRESS, BTN_TWO, 1'b0);
		configure(16'd0, 1'b1, 1'b1, 1'b1);
		send_event(FUNC_LONG, BTN_ONE, 1'b0);
		send_event(FUNC_PRESS, BTN_TWO, 1'b0);
	endtask

	task automatic touch_sequence(input logic [1:0] btn, input bit with_long);
		send_event(FUNC_PRESS, btn, 1'($urandom_range(0, 1)));
		if (with_long)
			send_event(FUNC_LONG, btn, 1'($urandom_range(0, 1)));
		send_event(FUNC_RELEASE, btn, 1'($urandom_range(0, 1)));
	endtask

	task automatic gesture_mix(input int n_events);
		int stop_at, pick, ticks, first;
		bit loco;
		stop_at = sent_events + n_events;
		while (sent_events < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				send_event(FUNC_LONG, BTN_ONE, 1'($urandom_range(0, 1)));
				ticks = $urandom_range(0, (win_ms > 8) ? 8 : win_ms + 2);
				repeat (ticks)
					send_event(FUNC_TICK, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)));
				touch_sequence(2'($urandom_range(2, 3)), $urandom_range(0, 99) < 40);
			end else if (pick < 40) begin
				touch_sequence(2'($urandom_range(2, 3)), $urandom_range(0, 99) < 40);
			end else if (pick < 56) begin
				loco = ($urandom_range(0, 99) < 75);
				first = $urandom_range(2, 3);
				send_event(FUNC_PRESS, 2'(first), loco);
				send_event(FUNC_PRESS, 2'(5 - first), loco);
				if ($urandom_range(0, 99) < 20)
					send_event(FUNC_LONG, 2'($urandom_range(2, 3)), loco);
				first = $urandom_range(2, 3);
				send_event(FUNC_RELEASE, 2'(first), loco);
				send_event(FUNC_RELEASE, 2'(5 - first), loco);
			end else if (pick < 70) begin
				send_event(FUNC_PRESS, BTN_ONE, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 99) < 30)
					send_event(FUNC_LONG, BTN_ONE, 1'($urandom_range(0, 1)));
				send_event(FUNC_RELEASE, BTN_ONE, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 99) < 40)
					send_event(FUNC_PHOTO_DONE, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)));
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 5))
					send_event(FUNC_TICK, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)));
				send_event(FUNC_PHOTO_DONE, 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, 3))
					send_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic test_random_phases();
		configure(16'd5, 1'b1, 1'b1, 1'b1);
		send_idle_pct = 0;
		stall_pct = 0;
		gesture_mix(400);
		configure(16'd0, 1'b1, 1'b0, 1'b1);
		send_idle_pct = 54;
		gesture_mix(300);
		configure(16'd3, 1'b1, 1'b1, 1'b1);
		send_idle_pct = 0;
		stall_pct = 54;
		gesture_mix(350);
		configure(16'hFFFF, 1'b0, 1'b1, 1'b1);
		send_idle_pct = 27;
		stall_pct = 27;
		gesture_mix(250);
		configure(16'd2, 1'b1, 1'b1, 1'b0);
		gesture_mix(200);
		configure(16'd1, 1'b1, 1'b1, 1'b1);
		send_idle_pct = 0;
		stall_pct = 0;
		gesture_mix(300);
	endtask

	initial begin
		reset_model();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_combo_window();
		test_steps_and_photo();
		test_dual_stop();
		test_ignored_events();
		test_no_motion_controller();
		test_random_phases();
		settle();
		repeat (8) @(negedge clk);
		if (expected_cmds.size() != 0)
			report_mismatch($sformatf("%0d commands never arrived", expected_cmds.size()));
		$display("covered %0d events, %0d commands checked, %0d register writes",
			sent_events, checked_cmds, config_writes);
		$display("gestures, combo window, dual stop, photo and idling phases; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("touch_gesture_command_decoder_core verification clean");
		else
			$display("touch_gesture_command_decoder_core verification failed");
		$finish;
	end

endmodule
